// File: rtl/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

  // Default geometry of the store.
  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;

  // Fixed field widths.
  localparam int MODE_W  = 2;
  localparam int CAP_W   = 5;
  localparam int EVICT_W = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Operation codes carried on the input side.
  localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Command broadcast from the controller to every cell of the row.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_DROP,
    CMD_EVICT,
    CMD_INSERT
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/lkvc_cell.sv
`default_nettype none

// One slot of the store: valid bit, key, value and recency rank.
// Free slots are claimed lowest first through the claim chain.
module lkvc_cell #(
  parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lkvc_pkg::cell_cmd_t           cmd,
  input  wire logic [KEY_BITS-1:0]           cmd_key,
  input  wire logic [VALUE_BITS-1:0]         cmd_value,
  input  wire logic [$clog2(ENTRIES+1)-1:0]  arg_a,
  input  wire logic [$clog2(ENTRIES+1)-1:0]  arg_b,
  input  wire logic                          taken_in,
  output logic                               taken_out,
  output logic                               hit,
  output logic [$clog2(ENTRIES)-1:0]         rank,
  output logic [VALUE_BITS-1:0]              value
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES+1);

  logic                valid;
  logic [KEY_BITS-1:0] key;
  logic [OCC_W-1:0]    rank_ext;
  logic                claim;

  assign rank_ext  = OCC_W'(rank);
  assign hit       = valid && (key == cmd_key);
  assign claim     = !valid && !taken_in;
  assign taken_out = taken_in || !valid;

  // Valid bit: the only state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd)
        lkvc_pkg::CMD_DROP: begin
          if (hit) valid <= 1'b0;
        end
        lkvc_pkg::CMD_EVICT: begin
          if (valid && (rank_ext < arg_a)) valid <= 1'b0;
        end
        lkvc_pkg::CMD_INSERT: begin
          if (claim) valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Key, value and rank follow the broadcast command.
  always_ff @(posedge clk) begin
    unique case (cmd)
      lkvc_pkg::CMD_TOUCH: begin
        if (hit) begin
          value <= cmd_value;
          rank  <= RANK_W'(arg_b);
        end else if (valid && (rank_ext > arg_a)) begin
          rank <= rank - 1'b1;
        end
      end
      lkvc_pkg::CMD_DROP: begin
        if (!hit && valid && (rank_ext > arg_a)) rank <= rank - 1'b1;
      end
      lkvc_pkg::CMD_EVICT: begin
        if (valid && (rank_ext >= arg_a)) rank <= RANK_W'(rank_ext - arg_a);
      end
      lkvc_pkg::CMD_INSERT: begin
        if (claim) begin
          key   <= cmd_key;
          value <= cmd_value;
          rank  <= RANK_W'(arg_b);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lru_key_value_cache_core.sv
`default_nettype none

// Channel   Direction  Signals                          Moves
// s_*       in         s_tvalid s_tready s_tdata s_tuser one operation
// m_*       out        m_tvalid m_tready m_tdata         one result
// cfg_*     in         cfg_valid cfg_ready cfg_data      capacity register write
//
// An operation is accepted in ST_IDLE; in ST_MATCH its key is matched across the
// row of cells and they are updated. A put of a new key that must evict also goes
// through ST_INSERT, because eviction and insertion are separate row updates.
// Synchronous reset clears the valid bits and occupancy and sets capacity to 16.
// A stalled result holds the row update that produces it; input waits meanwhile.
module lru_key_value_cache_core #(
  parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          s_tvalid,
  output logic                                               s_tready,
  // key, value
  input  wire logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]      s_tdata,
  // mode
  input  wire logic [lkvc_pkg::MODE_W-1:0]                   s_tuser,
  output logic                                               m_tvalid,
  input  wire logic                                          m_tready,
  // found, value_out, status, evicted_count
  output logic [((VALUE_BITS+7+7)/8)*8-1:0]                  m_tdata,
  input  wire logic                                          cfg_valid,
  output logic                                               cfg_ready,
  input  wire logic [lkvc_pkg::CAP_W-1:0]                    cfg_data
);

  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES+1);
  localparam int CMP_W   = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
  localparam int OUT_W   = ((VALUE_BITS+7+7)/8)*8;
  localparam int OUT_PAD = OUT_W - VALUE_BITS - 2 - lkvc_pkg::EVICT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_INSERT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [lkvc_pkg::CAP_W-1:0]   capacity;
  logic [OCC_W-1:0]             occupancy, occupancy_next;
  logic [lkvc_pkg::MODE_W-1:0]  op_mode;
  logic [KEY_BITS-1:0]          op_key;
  logic [VALUE_BITS-1:0]        op_value;
  logic [lkvc_pkg::EVICT_W-1:0] evict_cnt, evict_cnt_next;

  logic                         out_found, out_status;
  logic [VALUE_BITS-1:0]        out_value;
  logic [lkvc_pkg::EVICT_W-1:0] out_evict;
  logic                         emit, emit_found, emit_status;
  logic [VALUE_BITS-1:0]        emit_value;
  logic [lkvc_pkg::EVICT_W-1:0] emit_evict;

  lkvc_pkg::cell_cmd_t          cmd;
  logic [OCC_W-1:0]             arg_a, arg_b;

  logic [ENTRIES:0]             taken;
  logic [ENTRIES-1:0]           hit_vec;
  logic [RANK_W-1:0]            rank_vec  [ENTRIES];
  logic [VALUE_BITS-1:0]        value_vec [ENTRIES];
  logic                         hit_any;
  logic [RANK_W-1:0]            hit_rank;
  logic [VALUE_BITS-1:0]        hit_value;

  logic [CMP_W-1:0]             cap_wide;
  logic [OCC_W-1:0]             cap_eff;
  logic [OCC_W-1:0]             evict_n;
  logic                         can_emit;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign can_emit  = !m_tvalid || m_tready;
  assign m_tdata   = {{OUT_PAD{1'b0}}, out_evict, out_status, out_value, out_found};

  // Row of cells with the free-slot claim chain running through it.
  assign taken[0] = 1'b0;
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .cmd_key  (op_key),
      .cmd_value(op_value),
      .arg_a    (arg_a),
      .arg_b    (arg_b),
      .taken_in (taken[i]),
      .taken_out(taken[i+1]),
      .hit      (hit_vec[i]),
      .rank     (rank_vec[i]),
      .value    (value_vec[i])
    );
  end

  // Keys are unique among valid cells, so the hit fields can be OR-combined.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_rank  = hit_rank | rank_vec[i];
        hit_value = hit_value | value_vec[i];
      end
    end
  end
  assign hit_any = |hit_vec;

  // Effective capacity: zero acts as one, large values saturate at the row size.
  always_comb begin
    cap_wide = CMP_W'(capacity);
    if (cap_wide == '0) begin
      cap_wide = CMP_W'(1);
    end else if (cap_wide > CMP_W'(ENTRIES)) begin
      cap_wide = CMP_W'(ENTRIES);
    end
  end
  assign cap_eff = OCC_W'(cap_wide);
  assign evict_n = occupancy - cap_eff + 1'b1;

  // Controller: picks the row command and the result of each operation.
  always_comb begin
    state_next     = state;
    occupancy_next = occupancy;
    evict_cnt_next = evict_cnt;
    cmd            = lkvc_pkg::CMD_NONE;
    arg_a          = '0;
    arg_b          = '0;
    emit           = 1'b0;
    emit_found     = hit_any;
    emit_status    = 1'b0;
    emit_value     = '0;
    emit_evict     = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        priority if (op_mode == lkvc_pkg::MODE_PUT && hit_any) begin
          if (can_emit) begin
            cmd        = lkvc_pkg::CMD_TOUCH;
            arg_a      = OCC_W'(hit_rank);
            arg_b      = occupancy - 1'b1;
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (op_mode == lkvc_pkg::MODE_PUT && occupancy >= cap_eff) begin
          cmd            = lkvc_pkg::CMD_EVICT;
          arg_a          = evict_n;
          occupancy_next = occupancy - evict_n;
          evict_cnt_next = lkvc_pkg::EVICT_W'(evict_n);
          state_next     = ST_INSERT;
        end else if (op_mode == lkvc_pkg::MODE_PUT) begin
          if (can_emit) begin
            cmd            = lkvc_pkg::CMD_INSERT;
            arg_b          = occupancy;
            occupancy_next = occupancy + 1'b1;
            emit           = 1'b1;
            state_next     = ST_IDLE;
          end
        end else if (op_mode == lkvc_pkg::MODE_REMOVE) begin
          if (can_emit) begin
            if (hit_any) begin
              cmd            = lkvc_pkg::CMD_DROP;
              arg_a          = OCC_W'(hit_rank);
              occupancy_next = occupancy - 1'b1;
            end
            emit_status = !hit_any;
            emit        = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          // Lookup, and the unused code that behaves as one.
          if (can_emit) begin
            emit_value = hit_value;
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_INSERT: begin
        if (can_emit) begin
          cmd            = lkvc_pkg::CMD_INSERT;
          arg_b          = occupancy;
          occupancy_next = occupancy + 1'b1;
          emit_found     = 1'b0;
          emit_evict     = evict_cnt;
          emit           = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupancy <= '0;
      capacity  <= lkvc_pkg::CAPACITY_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      if (cfg_valid) capacity <= cfg_data;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Operation, eviction count and result payload registers.
  always_ff @(posedge clk) begin
    evict_cnt <= evict_cnt_next;
    if (s_tvalid && s_tready) begin
      op_mode  <= s_tuser;
      op_key   <= s_tdata[KEY_BITS-1:0];
      op_value <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
    end
    if (emit) begin
      out_found  <= emit_found;
      out_value  <= emit_value;
      out_status <= emit_status;
      out_evict  <= emit_evict;
    end
  end

endmodule

`default_nettype wire
